// ----- design/ducking_gain_curve_defines.svh -----
// assertion macros for the ducking gain curve checker
// expects clk and rst_n in the scope where a macro is used
`ifndef DUCKING_GAIN_CURVE_DEFINES_SVH
`define DUCKING_GAIN_CURVE_DEFINES_SVH

// same-cycle implication, off during reset
`define DGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define DGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// holds in the cycle after a reset edge
`define DGC_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ----- design/dgc_pkg.sv -----
// shared types, constants and table functions of the ducking gain curve
// no dependencies
package dgc_pkg;

  localparam int unsigned LOG_BITS   = 24;
  localparam int unsigned POW_LAT    = 2 * LOG_BITS + 3;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEP   = 16 / DIV_STAGES;

  typedef logic [16:0] q16_t;   // Q1.16
  typedef logic [15:0] expo_t;  // Q4.12

  localparam q16_t ONE = 17'h10000;

  typedef enum logic [2:0] {
    CURVE_SMOOTH  = 3'd0,
    CURVE_TIGHT   = 3'd1,
    CURVE_GARAGE  = 3'd2,
    CURVE_STUTTER = 3'd3,
    CURVE_GATE    = 3'd4
  } curve_t;

  typedef enum logic [1:0] {
    REG_CURVE_MODE   = 2'd0,
    REG_DUCK_DEPTH   = 2'd1,
    REG_CURVE_SHAPE  = 2'd2,
    REG_PHASE_OFFSET = 2'd3
  } reg_idx_t;

  // exponent end points, Q4.12
  localparam expo_t EXP_SMOOTH_LO  = 16'd1434;
  localparam expo_t EXP_SMOOTH_HI  = 16'd18432;
  localparam expo_t EXP_TIGHT_LO   = 16'd9011;
  localparam expo_t EXP_TIGHT_HI   = 16'd32768;
  localparam expo_t EXP_GARAGE_LO  = 16'd4506;
  localparam expo_t EXP_GARAGE_HI  = 16'd16384;
  localparam expo_t EXP_PULSE_LO   = 16'd4096;
  localparam expo_t EXP_PULSE_HI   = 16'd24576;
  localparam expo_t EXP_BASE_LO    = 16'd2458;
  localparam expo_t EXP_BASE_HI    = 16'd8192;
  localparam expo_t EXP_GATE       = 16'd32768;

  // hold lengths, Q0.16
  localparam logic [15:0] LEN_GARAGE_LO = 16'd6554;
  localparam logic [15:0] LEN_GARAGE_HI = 16'd18350;
  localparam logic [15:0] LEN_GATE_LO   = 16'd14418;
  localparam logic [15:0] LEN_GATE_HI   = 16'd38011;

  // stutter pulse constants
  localparam logic [15:0] STUT_T       = 16'd20972;
  localparam q16_t        STUT_DEN     = 17'd44564;
  localparam logic [15:0] STUT_BASE_K  = 16'd29491;
  localparam logic [15:0] STUT_PULSE_K = 16'd45875;

  typedef struct packed {
    logic [16:0] gain;
    logic [16:0] duck;
  } out_item_t;

  // unused mode codes fall back to smooth
  function automatic curve_t curve_of(logic [2:0] code);
    curve_t c;
    case (code)
      CURVE_TIGHT:   c = CURVE_TIGHT;
      CURVE_GARAGE:  c = CURVE_GARAGE;
      CURVE_STUTTER: c = CURVE_STUTTER;
      CURVE_GATE:    c = CURVE_GATE;
      default:       c = CURVE_SMOOTH;
    endcase
    return c;
  endfunction

  // round(2^60 / root_idx), root_idx = 2^30 * 2^(2^-idx) by repeated integer roots
  function automatic logic [30:0] inv_root(int unsigned idx);
    logic [63:0] root;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    root = 64'd1 << 31;
    for (int i = 1; i <= int'(LOG_BITS); i++) begin
      if (i <= int'(idx)) begin
        v    = root << 30;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
          if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
          end else begin
            res = res >> 1;
          end
          bitv = bitv >> 2;
        end
        root = res;
      end
    end
    num = (64'd1 << 60) + (root >> 1);
    rem = 64'd0;
    quo = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= root) begin
        rem    = rem - root;
        quo[j] = 1'b1;
      end
    end
    return quo[30:0];
  endfunction

endpackage

// ----- design/dgc_ifs.sv -----
// valid/ready stream interfaces for the ducking gain curve
// no dependencies
interface dgc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface dgc_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] gain;
  logic [16:0] duck;
  modport source (output valid, output gain, output duck, input ready);
  modport sink   (input valid, input gain, input duck, output ready);
endinterface

// ----- design/dgc_power.sv -----
// pipelined x^e as 2^(e*log2 x): squaring log stages then root-table exp stages
// depends on dgc_pkg
module dgc_power (
  input  logic          clk,
  input  logic          adv,
  input  dgc_pkg::q16_t  x,
  input  dgc_pkg::expo_t e,
  output dgc_pkg::q16_t  y
);
  import dgc_pkg::*;

  typedef struct packed {
    logic zero;
    logic one;
  } pflag_t;

  // log side
  logic [30:0]         m_r  [0:LOG_BITS];
  logic [LOG_BITS-1:0] fr_r [0:LOG_BITS];
  logic [3:0]          k_r  [0:LOG_BITS];
  expo_t               e_r  [0:LOG_BITS];
  pflag_t              lf_r [0:LOG_BITS];

  // normalise into [1,2) with 30 fraction bits
  logic [3:0]  k_c;
  logic [30:0] xw_c;
  always_comb begin
    k_c = 4'd0;
    for (int j = 0; j < 16; j++) begin
      if (x[j]) k_c = 4'(j);
    end
    xw_c = {15'd0, x[15:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0]     <= xw_c << (5'd30 - {1'b0, k_c});
      fr_r[0]    <= '0;
      k_r[0]     <= k_c;
      e_r[0]     <= e;
      lf_r[0].zero <= (x == 17'd0);
      lf_r[0].one  <= x[16] || (e == 16'd0);
    end
  end

  for (genvar i = 1; i <= LOG_BITS; i++) begin : g_log
    logic [61:0] sq_c;
    logic [31:0] t_c;
    always_comb begin
      sq_c = 62'(m_r[i-1]) * 62'(m_r[i-1]);
      t_c  = sq_c[61:30];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[i]  <= t_c[31] ? t_c[31:1] : t_c[30:0];
        fr_r[i] <= fr_r[i-1] | ({{(LOG_BITS-1){1'b0}}, t_c[31]} << (LOG_BITS - i));
        k_r[i]  <= k_r[i-1];
        e_r[i]  <= e_r[i-1];
        lf_r[i] <= lf_r[i-1];
      end
    end
  end

  // scale by exponent
  logic [28:0] lg_c;
  logic [44:0] pr_c;
  logic [32:0] p_r;
  pflag_t      pf_r;
  always_comb begin
    lg_c = {5'(5'd16 - {1'b0, k_r[LOG_BITS]}), {LOG_BITS{1'b0}}} - {5'd0, fr_r[LOG_BITS]};
    pr_c = 45'(lg_c) * 45'(e_r[LOG_BITS]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= pr_c[44:12];
      pf_r <= lf_r[LOG_BITS];
    end
  end

  // exp side: one table factor per fraction bit
  logic [30:0]         res_r [0:LOG_BITS];
  logic [LOG_BITS-1:0] f_r   [0:LOG_BITS];
  logic [8:0]          n_r   [0:LOG_BITS];
  pflag_t              xf_r  [0:LOG_BITS];

  always_comb begin
    res_r[0] = 31'h4000_0000;
    f_r[0]   = p_r[LOG_BITS-1:0];
    n_r[0]   = p_r[32:LOG_BITS];
    xf_r[0]  = pf_r;
  end

  for (genvar j = 1; j <= LOG_BITS; j++) begin : g_exp
    localparam logic [30:0] K = inv_root(j);
    logic [61:0] mul_c;
    always_comb mul_c = 62'(res_r[j-1]) * 62'(K);
    always_ff @(posedge clk) begin
      if (adv) begin
        res_r[j] <= f_r[j-1][LOG_BITS-j] ? mul_c[60:30] : res_r[j-1];
        f_r[j]   <= f_r[j-1];
        n_r[j]   <= n_r[j-1];
        xf_r[j]  <= xf_r[j-1];
      end
    end
  end

  // round back to 16 fraction bits
  logic [4:0]  sh_c;
  logic [31:0] rnd_c;
  q16_t        y_nxt;
  q16_t        y_r;
  always_comb begin
    sh_c  = 5'(5'd14 + n_r[LOG_BITS][4:0]);
    rnd_c = ({1'b0, res_r[LOG_BITS]} + (32'd1 << (sh_c - 5'd1))) >> sh_c;
    if (xf_r[LOG_BITS].zero) begin
      y_nxt = '0;
    end else if (xf_r[LOG_BITS].one) begin
      y_nxt = ONE;
    end else if (n_r[LOG_BITS] > 9'd17) begin
      y_nxt = '0;
    end else if (rnd_c > 32'(ONE)) begin
      y_nxt = ONE;
    end else begin
      y_nxt = rnd_c[16:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) y_r <= y_nxt;
  end
  assign y = y_r;

endmodule

// ----- design/ducking_gain_curve.sv -----
// top level of the ducking gain curve: config registers, front end, divider,
// two power pipelines, depth stage and output queue; depends on dgc_pkg, dgc_ifs, dgc_power
//
// Takes one position per cycle and returns gain and raw duck for it, one result per
// transfer, in order. The datapath is a single pipeline that never stalls an item
// internally: a new position is taken in every cycle while the two-entry output queue
// has room, and each result is registered in turn by the phase add, release set-up,
// divider, power pipeline, duck combine and depth stages and then the output queue.
// The power pipeline is the longest part: it squares once per stage for 24 log bits
// and multiplies once per stage by 24 root-table factors. Config writes land in the
// registers at once; exponents and hold lengths derived from them follow in the
// cycle after, so writes belong to times when no item is in flight.
module ducking_gain_curve (
  input  logic             clk,
  input  logic             rst_n,
  dgc_in_if.sink           in_ch,
  dgc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [16:0]      cfg_data
);
  import dgc_pkg::*;

  typedef struct packed {
    curve_t cur;
    logic   hold;
    q16_t   inv;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [2:0]  mode_r;
  logic [16:0] depth_r;
  logic [15:0] shape_r;
  logic [15:0] phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 3'(CURVE_SMOOTH);
      depth_r <= ONE;
      shape_r <= 16'h8000;
      phase_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURVE_MODE:   mode_r  <= cfg_data[2:0];
        REG_DUCK_DEPTH:   depth_r <= cfg_data;
        REG_CURVE_SHAPE:  shape_r <= cfg_data[15:0];
        REG_PHASE_OFFSET: phase_r <= cfg_data[15:0];
        default:          mode_r  <= mode_r;
      endcase
    end
  end

  // a + (b - a) * shape, rounded
  function automatic logic [15:0] map_shape(logic [15:0] a, logic [15:0] b,
                                            logic [15:0] s);
    logic [31:0] prod;
    prod = 32'(b - a) * 32'(s) + 32'd32768;
    return a + prod[31:16];
  endfunction

  // ---------------- shape-derived values, registered behind config ----------------
  curve_t      cur_cfg;
  expo_t       ea_c, eb_c;
  logic [15:0] la_c, lb_c;
  expo_t       emain_nxt, ebase_nxt;
  logic [15:0] len_nxt;
  q16_t        dsat_nxt;
  expo_t       emain_r, ebase_r;
  logic [15:0] len_r;
  q16_t        dsat_r;

  always_comb begin
    cur_cfg = curve_of(mode_r);
    la_c    = 16'd0;
    lb_c    = 16'd0;
    case (cur_cfg)
      CURVE_TIGHT: begin
        ea_c = EXP_TIGHT_LO;
        eb_c = EXP_TIGHT_HI;
      end
      CURVE_GARAGE: begin
        ea_c = EXP_GARAGE_LO;
        eb_c = EXP_GARAGE_HI;
        la_c = LEN_GARAGE_LO;
        lb_c = LEN_GARAGE_HI;
      end
      CURVE_STUTTER: begin
        ea_c = EXP_PULSE_LO;
        eb_c = EXP_PULSE_HI;
      end
      CURVE_GATE: begin
        ea_c = EXP_GATE;
        eb_c = EXP_GATE;
        la_c = LEN_GATE_LO;
        lb_c = LEN_GATE_HI;
      end
      default: begin
        ea_c = EXP_SMOOTH_LO;
        eb_c = EXP_SMOOTH_HI;
      end
    endcase
    emain_nxt = map_shape(ea_c, eb_c, shape_r);
    ebase_nxt = map_shape(EXP_BASE_LO, EXP_BASE_HI, shape_r);
    len_nxt   = map_shape(la_c, lb_c, shape_r);
    // depth above one saturates
    dsat_nxt  = (depth_r > ONE) ? ONE : depth_r;
  end

  always_ff @(posedge clk) begin
    emain_r <= emain_nxt;
    ebase_r <= ebase_nxt;
    len_r   <= len_nxt;
    dsat_r  <= dsat_nxt;
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt_r;
  logic       adv;
  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;

  // ---------------- stage a: phase offset, wraps mod one ----------------
  logic        va_r;
  logic [15:0] ra_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) ra_r <= in_ch.position + phase_r;
  end

  // ---------------- stage b: hold test and release quotient set-up ----------------
  curve_t      cur_b;
  logic        hold_b;
  logic [15:0] num_b;
  q16_t        den_b;
  logic [15:0] p4_b;

  always_comb begin
    cur_b  = curve_of(mode_r);
    p4_b   = {ra_r[13:0], 2'b00};
    hold_b = 1'b0;
    num_b  = 16'd0;
    den_b  = ONE;
    case (cur_b)
      CURVE_GARAGE, CURVE_GATE: begin
        hold_b = (ra_r <= len_r);
        num_b  = hold_b ? 16'd0 : ra_r - len_r;
        den_b  = ONE - {1'b0, len_r};
      end
      CURVE_STUTTER: begin
        // four pulses per position period, flat top before the pulse release
        hold_b = (p4_b < STUT_T);
        num_b  = hold_b ? 16'd0 : p4_b - STUT_T;
        den_b  = STUT_DEN;
      end
      default: begin
        hold_b = 1'b0;
      end
    endcase
  end

  logic        dv_r  [0:DIV_STAGES];
  side_t       ds_r  [0:DIV_STAGES];
  logic [16:0] rem_r [0:DIV_STAGES];
  logic [15:0] quo_r [0:DIV_STAGES];
  q16_t        den_r [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= va_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0].cur  <= cur_b;
      ds_r[0].hold <= hold_b;
      ds_r[0].inv  <= ONE - {1'b0, ra_r};
      rem_r[0]     <= {1'b0, num_b};
      quo_r[0]     <= 16'd0;
      den_r[0]     <= den_b;
    end
  end

  // ---------------- restoring divider, DIV_STEP quotient bits per stage ----------------
  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
    logic [16:0] rem_c;
    logic [17:0] t_c;
    logic [15:0] quo_c;
    always_comb begin
      rem_c = rem_r[i-1];
      quo_c = quo_r[i-1];
      t_c   = '0;
      for (int b = 0; b < int'(DIV_STEP); b++) begin
        t_c = {rem_c, 1'b0};
        if (t_c >= {1'b0, den_r[i-1]}) begin
          rem_c = 17'(t_c - {1'b0, den_r[i-1]});
          quo_c = {quo_c[14:0], 1'b1};
        end else begin
          rem_c = t_c[16:0];
          quo_c = {quo_c[14:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else if (adv) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[i]  <= ds_r[i-1];
        rem_r[i] <= rem_c;
        quo_r[i] <= quo_c;
        den_r[i] <= den_r[i-1];
      end
    end
  end

  // ---------------- power pipelines ----------------
  q16_t x_main_c;
  q16_t pow_main;
  q16_t pow_base;

  always_comb begin
    case (ds_r[DIV_STAGES].cur)
      CURVE_GARAGE, CURVE_GATE, CURVE_STUTTER:
        x_main_c = ONE - {1'b0, quo_r[DIV_STAGES]};
      default:
        x_main_c = ds_r[DIV_STAGES].inv;
    endcase
  end

  dgc_power u_pow_main (
    .clk (clk),
    .adv (adv),
    .x   (x_main_c),
    .e   (emain_r),
    .y   (pow_main)
  );

  // stutter base envelope
  dgc_power u_pow_base (
    .clk (clk),
    .adv (adv),
    .x   (ds_r[DIV_STAGES].inv),
    .e   (ebase_r),
    .y   (pow_base)
  );

  // side data rides alongside the power pipelines
  logic  sv_r [1:POW_LAT];
  side_t sd_r [1:POW_LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= int'(POW_LAT); i++) sv_r[i] <= 1'b0;
    end else if (adv) begin
      sv_r[1] <= dv_r[DIV_STAGES];
      for (int i = 2; i <= int'(POW_LAT); i++) sv_r[i] <= sv_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[1] <= ds_r[DIV_STAGES];
      for (int i = 2; i <= int'(POW_LAT); i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // ---------------- stage g1: hold override and stutter weights ----------------
  q16_t        dmain_c;
  logic [33:0] ap_c, bp_c;
  logic        g1v_r;
  curve_t      g1cur_r;
  q16_t        g1d_r, g1a_r, g1b_r;

  always_comb begin
    dmain_c = sd_r[POW_LAT].hold ? ONE : pow_main;
    ap_c    = 34'(pow_base) * 34'(STUT_BASE_K) + 34'd32768;
    bp_c    = 34'(dmain_c) * 34'(STUT_PULSE_K) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1v_r <= 1'b0;
    end else if (adv) begin
      g1v_r <= sv_r[POW_LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g1cur_r <= sd_r[POW_LAT].cur;
      g1d_r   <= dmain_c;
      g1a_r   <= ap_c[32:16];
      g1b_r   <= bp_c[32:16];
    end
  end

  // ---------------- stage g2: duck select and depth ----------------
  q16_t        mx_c, duck_c;
  logic [33:0] lp_c;
  logic        g2v_r;
  q16_t        g2loss_r, g2duck_r;

  always_comb begin
    mx_c   = (g1a_r > g1b_r) ? g1a_r : g1b_r;
    duck_c = (g1cur_r == CURVE_STUTTER) ? ((mx_c > ONE) ? ONE : mx_c) : g1d_r;
    lp_c   = 34'(dsat_r) * 34'(duck_c) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2v_r <= 1'b0;
    end else if (adv) begin
      g2v_r <= g1v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g2loss_r <= lp_c[32:16];
      g2duck_r <= duck_c;
    end
  end

  // ---------------- two-entry output queue ----------------
  out_item_t item_c;
  out_item_t head_r, tail_r, head_nxt, tail_nxt;
  logic [1:0] cnt_nxt;
  logic       push, pop;

  assign push = adv && g2v_r;
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    // gain clamped at zero
    item_c.gain = (g2loss_r >= ONE) ? 17'd0 : ONE - g2loss_r;
    item_c.duck = g2duck_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) head_nxt = item_c;
        else               tail_nxt = item_c;
        cnt_nxt = 2'(cnt_r + 2'd1);
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = 2'(cnt_r - 2'd1);
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = item_c;
        end else begin
          head_nxt = tail_r;
          tail_nxt = item_c;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.gain  = head_r.gain;
  assign out_ch.duck  = head_r.duck;

endmodule

// ----- design/dgc_checker.sv -----
// port-level checks of the ducking gain curve, bound to the top level
// depends on dgc_pkg and ducking_gain_curve_defines.svh
`include "ducking_gain_curve_defines.svh"

module dgc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input dgc_pkg::q16_t out_gain,
  input dgc_pkg::q16_t out_duck
);
  import dgc_pkg::*;

  `DGC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `DGC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_gain) && $stable(out_duck), "result changed while stalled")
  `DGC_ASSERT_NOW(a_zero_duck, out_valid && out_duck == 17'd0, out_gain == ONE, "no duck must give unity gain")
  `DGC_ASSERT_RESET(a_reset_empty, !out_valid, "result shown after reset")

endmodule

bind ducking_gain_curve dgc_checker u_dgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_gain  (out_ch.gain),
  .out_duck  (out_ch.duck)
);

// ----- tb/sv/dgc_tb_ifs.sv -----
`timescale 1ns / 1ps
// bench-side note on the stream interfaces of the ducking gain curve
// the bench takes dgc_in_if and dgc_out_if from the design folder, so nothing is declared here

// ----- tb/sv/tb_ducking_gain_curve.sv -----
`timescale 1ns / 1ps
// bench for ducking_gain_curve: random and directed positions across all curves
// depends on dgc_pkg, dgc_ifs and the block itself
module tb_ducking_gain_curve;
  import dgc_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;
  int errors;

  dgc_in_if in_ch();
  dgc_out_if out_ch();

  ducking_gain_curve DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // gain model state: registers and the root table
  logic [2:0] mode_r;
  logic [16:0] depth_r;
  logic [15:0] shape_r, phase_r;
  logic [63:0] root_tab [1:24];

  function automatic logic [63:0] sqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic fill_roots();
    logic [63:0] rt;
    rt = 64'd1 << 31;
    for (int i = 1; i <= 24; i++) begin
      rt = sqrt64(rt << 30);
      root_tab[i] = ((64'd1 << 60) + rt / 2) / rt;
    end
  endtask

  function automatic logic [63:0] lerp_exp(logic [63:0] a, logic [63:0] b);
    return a + (((b - a) * shape_r + 32768) >> 16);
  endfunction

  // x^e with x in Q.16 and e in Q4.12, via log2 then exp2
  function automatic logic [63:0] pow_q(logic [63:0] x, logic [63:0] e);
    logic [63:0] m, fr, lg, p, f, res;
    int k, n, sh;
    fr = 0;
    res = 64'd1 << 30;
    k = 0;
    if (x == 0) return 0;
    if (x >= 65536 || e == 0) return 65536;
    while ((x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr[23 - i] = 1'b1;
      end
    end
    lg = (64'(16 - k) << 24) - fr;
    p = (lg * e) >> 12;
    if ((p >> 24) > 62) return 0;
    n = int'(p >> 24);
    f = p & 64'hFFFFFF;
    for (int i = 1; i <= 24; i++)
      if (f[24 - i]) res = (res * root_tab[i]) >> 30;
    sh = 14 + n;
    if (sh > 62) return 0;
    res = (res + (64'd1 << (sh - 1))) >> sh;
    return res > 65536 ? 65536 : res;
  endfunction

  function automatic logic [63:0] release_of(logic [63:0] r, logic [63:0] len);
    logic [63:0] den, rel;
    den = 65536 - len;
    if (den == 0) den = 1;
    rel = ((r - len) << 16) / den;
    if (rel > 65536) rel = 65536;
    return 65536 - rel;
  endfunction

  function automatic logic [63:0] duck_amount(logic [63:0] r);
    logic [63:0] inv, len, t, p, pd, bs, a, b;
    inv = 65536 - r;
    case (curve_of(mode_r))
      CURVE_TIGHT: return pow_q(inv, lerp_exp(EXP_TIGHT_LO, EXP_TIGHT_HI));
      CURVE_GARAGE: begin
        len = lerp_exp(LEN_GARAGE_LO, LEN_GARAGE_HI);
        if (r <= len) return 65536;
        return pow_q(release_of(r, len), lerp_exp(EXP_GARAGE_LO, EXP_GARAGE_HI));
      end
      CURVE_STUTTER: begin
        t = STUT_T;
        p = (r * 4) & 64'hFFFF;
        if (p < t) pd = 65536;
        else pd = pow_q(65536 - ((p - t) << 16) / (65536 - t),
                        lerp_exp(EXP_PULSE_LO, EXP_PULSE_HI));
        bs = pow_q(inv, lerp_exp(EXP_BASE_LO, EXP_BASE_HI));
        a = (bs * STUT_BASE_K + 32768) >> 16;
        b = (pd * STUT_PULSE_K + 32768) >> 16;
        a = a > b ? a : b;
        return a > 65536 ? 65536 : a;
      end
      CURVE_GATE: begin
        len = lerp_exp(LEN_GATE_LO, LEN_GATE_HI);
        if (r <= len) return 65536;
        return pow_q(release_of(r, len), EXP_GATE);
      end
      default: return pow_q(inv, lerp_exp(EXP_SMOOTH_LO, EXP_SMOOTH_HI));
    endcase
  endfunction

  function automatic out_item_t gain_of(logic [15:0] pos);
    logic [63:0] r, dk, dp, loss;
    out_item_t o;
    r = 64'(16'(pos + phase_r));
    dk = duck_amount(r);
    dp = depth_r > 65536 ? 65536 : depth_r;
    loss = (dp * dk + 32768) >> 16;
    o.gain = loss >= 65536 ? 17'd0 : 17'(65536 - loss);
    o.duck = 17'(dk);
    return o;
  endfunction

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    if (errors <= 20)
      $display("mismatch %s: got gain %0d duck %0d, want gain %0d duck %0d",
               what, got.gain, got.duck, want.gain, want.duck);
  endtask

  // holds expected results in transfer order
  class gain_board;
    out_item_t pending[$];
    int checked;
    function void note(logic [15:0] pos);
      pending.push_back(gain_of(pos));
    endfunction
    task check(out_item_t got);
      out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.gain !== want.gain) report("gain", got, want);
      if (got.duck !== want.duck) report("duck", got, want);
    endtask
  endclass

  gain_board board;
  int send_idle, recv_idle;
  bit hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input transfers feed the model, output transfers are checked
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) board.note(in_ch.position);
    if (rst_n && out_ch.valid && out_ch.ready) board.check({out_ch.gain, out_ch.duck});
  end

  // receiver stalls at random, or holds off fully during the pressure phase
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // valid stays up after the last transfer; drain() drops it
  task automatic send(logic [15:0] pos);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stops offering, waits for the pipeline to drain, then waits longer than the datapath latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CURVE_MODE: mode_r = val[2:0];
      REG_DUCK_DEPTH: depth_r = val;
      REG_CURVE_SHAPE: shape_r = val[15:0];
      default: phase_r = val[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic setup(logic [2:0] m, logic [16:0] d, logic [15:0] s, logic [15:0] ph);
    drain();
    write_reg(REG_CURVE_MODE, 17'(m));
    write_reg(REG_DUCK_DEPTH, d);
    write_reg(REG_CURVE_SHAPE, 17'(s));
    write_reg(REG_PHASE_OFFSET, 17'(ph));
  endtask

  // positions lean towards both ends of the range and towards STUT_T offsets now and then
  function automatic logic [15:0] rand_pos();
    case ($urandom_range(5))
      0: return 16'($urandom_range(3));
      1: return 16'hFFFF - 16'($urandom_range(3));
      2: return 16'(STUT_T + $urandom_range(8) - 4 + 16384 * $urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int total;
    board = new();
    errors = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_CURVE_MODE;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.position = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_off = 0;
    mode_r = 0;
    depth_r = 17'h10000;
    shape_r = 16'h8000;
    phase_r = 0;
    fill_roots();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then every mode code at shape and depth extremes
    send(16'h0000);
    send(16'hFFFF);
    send(16'h8000);
    for (int c = 0; c < 8; c++) begin
      setup(3'(c), c[0] ? 17'h10000 : 17'h1FFFF, c[1] ? 16'hFFFF : 16'h0000, 16'h0000);
      send(16'h0000);
      send(16'hFFFF);
      send(16'(STUT_T));
    end
    setup(CURVE_GATE, 17'd0, 16'hFFFF, 16'hFFFF);
    send(16'h0001);
    send(16'h5555);

    // pressure: receiver holds off while the sender keeps offering
    setup(CURVE_STUTTER, 17'h0AAAA, 16'h1234, 16'h0100);
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 100; i++) send(rand_pos());
    join

    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 28 : (ph == 1 ? 75 : 0);
      recv_idle = ph == 0 ? 75 : (ph == 1 ? 28 : 0);
      for (int blk = 0; blk < 8; blk++) begin
        setup(3'($urandom_range(7)),
              $urandom_range(3) == 0 ? 17'($urandom_range(1) * 65536) :
                                       17'($urandom_range(131071)),
              $urandom_range(3) == 0 ? 16'($urandom_range(1) * 65535) : 16'($urandom),
              16'($urandom));
        for (int i = 0; i < 48; i++) begin
          send(rand_pos());
          total++;
        end
      end
    end
    send_idle = 0;
    recv_idle = 0;
    drain();
    $display("checked %0d results (%0d random) over all five curves, unused mode codes and",
             board.checked, total);
    $display("depth and shape extremes, under sender and receiver stalls");
    if (errors == 0) begin
      $display("PASS ducking_gain_curve");
    end else begin
      $display("FAIL ducking_gain_curve");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL ducking_gain_curve");
    $finish;
  end
endmodule
